>>> rtl/cht_pkg.sv
// Shared constants, codes and a helper function for the chained hash table.
// No dependencies.
package cht_pkg;

    localparam int P_MAX_ENTRIES  = 1024;
    localparam int P_MAX_BUCKETS  = 2048;
    localparam int P_INIT_BUCKETS = 16;
    localparam int P_VALUE_WIDTH  = 32;

    localparam int KEY_W       = 31;
    localparam int LIMIT_W     = 3;
    localparam int STATUS_W    = 2;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // largest power of two not above n
    function automatic int f_pow2_floor(input int n);
        int p;
        p = 1;
        while (p * 2 <= n) begin
            p = p * 2;
        end
        return p;
    endfunction

endpackage

>>> rtl/cht_ifs.sv
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on cht_pkg.
interface cht_req_if #(parameter int VW = 32);
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [cht_pkg::KEY_W-1:0]  key;
    logic [VW-1:0]              data_in;
    modport source (output valid, cmd, key, data_in, input ready);
    modport sink   (input valid, cmd, key, data_in, output ready);
endinterface

interface cht_rsp_if #(parameter int VW = 32, parameter int CW = 11);
    logic                         valid;
    logic                         ready;
    logic [cht_pkg::STATUS_W-1:0] status;
    logic [VW-1:0]                data_out;
    logic [CW-1:0]                compares;
    modport source (output valid, status, data_out, compares, input ready);
    modport sink   (input valid, status, data_out, compares, output ready);
endinterface

interface cht_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [cht_pkg::LIMIT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/cht_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
module cht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/chained_hash_table.sv
// Chained hash table top level: sequencer over bucket-head and node-pool RAMs.
// Depends on cht_pkg, cht_ifs, cht_ram.
//
// Usage:
//   i_req  : one item per operation, cmd 0 inserts key/data_in, cmd 1 looks up key.
//   o_rsp  : exactly one item per request: status, data_out, compares.
//   i_cfg  : writes limit_quarters; always ready, write only while idle.
// Sequence: an insert passes check, head read and write states (straight to the result
//   when the pool is full); a lookup reads the head, then walks the chain node by node.
//   An insert that grows the table also re-splits every old bucket, walking each stored
//   node in turn through the shared node-RAM read address.
// One request is in flight at a time; i_req.ready is high only when idle,
//   in the cycle after the previous result is loaded into the output register.
// A finished result waits in the output register; if the receiver stalls,
//   the next request is still taken and its result holds until the output frees.
// After reset a clearing pass writes the initial bucket heads empty,
//   one bucket after another (16 by default) before ready rises.
module chained_hash_table #(
    parameter int MAX_ENTRIES  = cht_pkg::P_MAX_ENTRIES,
    parameter int MAX_BUCKETS  = cht_pkg::P_MAX_BUCKETS,
    parameter int INIT_BUCKETS = cht_pkg::P_INIT_BUCKETS,
    parameter int VALUE_WIDTH  = cht_pkg::P_VALUE_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cht_req_if.sink   i_req,
    cht_rsp_if.source o_rsp,
    cht_cfg_if.sink   i_cfg
);
    import cht_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int BW = $clog2(MAX_BUCKETS);
    localparam int GW = NW + BW + 4;
    localparam int INIT_POW = f_pow2_floor(INIT_BUCKETS);
    localparam logic [NW-1:0] EMPTY = NW'(MAX_ENTRIES);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CHK    = 4'd2;
    localparam logic [3:0] S_G_HEAD = 4'd3;
    localparam logic [3:0] S_G_HDAT = 4'd4;
    localparam logic [3:0] S_G_NODE = 4'd5;
    localparam logic [3:0] S_G_WLO  = 4'd6;
    localparam logic [3:0] S_G_WHI  = 4'd7;
    localparam logic [3:0] S_I_HEAD = 4'd8;
    localparam logic [3:0] S_I_WR   = 4'd9;
    localparam logic [3:0] S_L_HEAD = 4'd10;
    localparam logic [3:0] S_L_HDAT = 4'd11;
    localparam logic [3:0] S_L_NODE = 4'd12;
    localparam logic [3:0] S_EMIT   = 4'd13;

    logic [3:0]             r_state, n_state;
    logic [BW-1:0]          r_b;
    logic [NW-1:0]          r_walk, r_lo, r_hi;
    logic [BW:0]            r_nb;
    logic [BW-1:0]          r_mask;
    logic [NW-1:0]          r_cnt;
    logic [LIMIT_W-1:0]     r_limit;
    logic [KEY_W-1:0]       r_key;
    logic [VALUE_WIDTH-1:0] r_data;
    logic [NW-1:0]          r_cmp;
    logic [STATUS_W-1:0]    r_status;
    logic [VALUE_WIDTH-1:0] r_found;
    logic                   r_ovalid;
    logic [STATUS_W-1:0]    r_ostatus;
    logic [VALUE_WIDTH-1:0] r_odata;
    logic [NW-1:0]          r_ocmp;

    logic                   w_accept;
    logic [BW-1:0]          w_slot;
    logic                   w_grow;
    logic                   w_out_free;

    logic                   head_we;
    logic [BW-1:0]          head_waddr, head_raddr;
    logic [NW-1:0]          head_wdata, head_rd;
    logic                   node_we, link_we;
    logic [AW-1:0]          node_raddr, link_waddr;
    logic [NW-1:0]          link_wdata, link_rd;
    logic [KEY_W-1:0]       key_rd;
    logic [VALUE_WIDTH-1:0] val_rd;
    logic                   w_hi_bit;

    assign w_accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_slot     = r_key[BW-1:0] & r_mask;
    assign w_out_free = !r_ovalid || o_rsp.ready;
    assign w_hi_bit   = |({1'b0, key_rd[BW-1:0]} & r_nb);
    assign w_grow     = ({{(GW-NW-2){1'b0}}, r_cnt, 2'b00} > GW'(r_limit) * GW'(r_nb))
                        && ((GW'(r_nb) << 1) <= GW'(MAX_BUCKETS));

    // bucket head RAM ports
    always_comb begin
        head_we    = 1'b0;
        head_waddr = r_b;
        head_wdata = EMPTY;
        head_raddr = w_slot;
        unique case (r_state)
            S_CLR: begin
                head_we = 1'b1;
            end
            S_G_HEAD: begin
                head_raddr = r_b;
            end
            S_G_WLO: begin
                head_we    = 1'b1;
                head_wdata = r_lo;
            end
            S_G_WHI: begin
                head_we    = 1'b1;
                head_waddr = r_b + r_nb[BW-1:0];
                head_wdata = r_hi;
            end
            S_I_WR: begin
                head_we    = 1'b1;
                head_waddr = w_slot;
                head_wdata = r_cnt;
            end
            default: begin
            end
        endcase
    end

    // node pool RAM ports
    always_comb begin
        node_we    = (r_state == S_I_WR);
        link_we    = 1'b0;
        link_waddr = r_cnt[AW-1:0];
        link_wdata = head_rd;
        node_raddr = link_rd[AW-1:0];
        unique case (r_state)
            S_G_HDAT, S_L_HDAT: begin
                node_raddr = head_rd[AW-1:0];
            end
            S_G_NODE: begin
                link_we    = 1'b1;
                link_waddr = r_walk[AW-1:0];
                link_wdata = w_hi_bit ? r_hi : r_lo;
            end
            S_I_WR: begin
                link_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    cht_ram #(.WIDTH(NW), .DEPTH(MAX_BUCKETS)) u_heads (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_rd)
    );
    cht_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_keys (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(r_cnt[AW-1:0]), .i_wdata(r_key),
        .i_raddr(node_raddr), .o_rdata(key_rd)
    );
    cht_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ENTRIES)) u_vals (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(r_cnt[AW-1:0]), .i_wdata(r_data),
        .i_raddr(node_raddr), .o_rdata(val_rd)
    );
    cht_ram #(.WIDTH(NW), .DEPTH(MAX_ENTRIES)) u_links (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_raddr(node_raddr), .o_rdata(link_rd)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:    if (r_b == BW'(INIT_POW - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.cmd == CMD_LOOKUP) begin
                        n_state = S_L_HEAD;
                    end else if (r_cnt >= EMPTY) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK:    n_state = w_grow ? S_G_HEAD : S_I_HEAD;
            S_G_HEAD: n_state = S_G_HDAT;
            S_G_HDAT: n_state = (head_rd < EMPTY) ? S_G_NODE : S_G_WLO;
            S_G_NODE: if (link_rd >= EMPTY) n_state = S_G_WLO;
            S_G_WLO:  n_state = S_G_WHI;
            S_G_WHI:  n_state = (r_b == r_mask) ? S_I_HEAD : S_G_HEAD;
            S_I_HEAD: n_state = S_I_WR;
            S_I_WR:   n_state = S_EMIT;
            S_L_HEAD: n_state = S_L_HDAT;
            S_L_HDAT: n_state = (head_rd < EMPTY) ? S_L_NODE : S_EMIT;
            S_L_NODE: if (key_rd == r_key || link_rd >= EMPTY) n_state = S_EMIT;
            S_EMIT:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_b      <= '0;
            r_nb     <= (BW+1)'(INIT_POW);
            r_mask   <= BW'(INIT_POW - 1);
            r_cnt    <= '0;
            r_limit  <= LIMIT_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_limit <= i_cfg.data;
            end
            if (r_state == S_EMIT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_b <= (r_b == BW'(INIT_POW - 1)) ? '0 : r_b + 1'b1;
                end
                S_IDLE: begin
                    r_key    <= i_req.key;
                    r_data   <= i_req.data_in;
                    r_cmp    <= '0;
                    r_found  <= '0;
                    r_b      <= '0;
                    r_status <= (i_req.cmd == CMD_LOOKUP) ? ST_MISS :
                                (r_cnt >= EMPTY) ? ST_FULL : ST_INSERTED;
                end
                S_G_HDAT: begin
                    r_walk <= head_rd;
                    r_lo   <= EMPTY;
                    r_hi   <= EMPTY;
                end
                S_G_NODE: begin
                    if (w_hi_bit) begin
                        r_hi <= r_walk;
                    end else begin
                        r_lo <= r_walk;
                    end
                    r_walk <= link_rd;
                end
                S_G_WHI: begin
                    r_b <= r_b + 1'b1;
                    if (r_b == r_mask) begin
                        r_nb   <= r_nb << 1;
                        r_mask <= {r_mask[BW-2:0], 1'b1};
                    end
                end
                S_I_WR: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                S_L_NODE: begin
                    r_cmp <= r_cmp + 1'b1;
                    if (key_rd == r_key) begin
                        r_status <= ST_FOUND;
                        r_found  <= val_rd;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_ostatus <= r_status;
                        r_odata   <= r_found;
                        r_ocmp    <= r_cmp;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_rsp.valid    = r_ovalid;
    assign o_rsp.status   = r_ostatus;
    assign o_rsp.data_out = r_odata;
    assign o_rsp.compares = r_ocmp;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= EMPTY) else $error("entry count beyond pool");
    a_nb_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_nb)) else $error("bucket count not a power of two");
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready) else $error("second item taken while busy");
    a_found_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_FOUND) |-> (o_rsp.compares != '0))
        else $error("hit reported with no comparisons");
endmodule
